>>> hdl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants
// Transaction payloads, event codes and queue entry format for the I2C
// master event sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam logic [23:0] EV_START_SENT    = 24'h030001;
  localparam logic [23:0] EV_TX_ADDR_SENT  = 24'h070082;
  localparam logic [23:0] EV_TX_BYTE_DONE  = 24'h070084;
  localparam logic [23:0] EV_RX_ADDR_SENT  = 24'h030002;
  localparam logic [23:0] EV_RX_BYTE_READY = 24'h030044;
  localparam logic [15:0] ERROR_FLAG_MASK  = 16'hff00;
  localparam logic [7:0]  RW_BIT           = 8'h01;

  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_ON   = 2'd1;
  localparam logic [1:0] ACK_OFF  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNLISTED = 3'd6;

  typedef enum logic [2:0] {
    OP_START,
    OP_START_SENT,
    OP_TX_BYTE,
    OP_RX_ADDR,
    OP_RX_BYTE,
    OP_ERROR,
    OP_OTHER
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] status_word;
    logic [7:0]  slave_address;
    logic [7:0]  write_count;
    logic [7:0]  read_count;
    logic        has_write;
    logic        has_read;
    logic [7:0]  write_byte;
    logic [7:0]  read_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_address;
    logic       send_data_byte;
    logic [7:0] out_byte;
    logic [7:0] buffer_index;
    logic       store_read;
    logic       make_start;
    logic       make_stop;
    logic [1:0] ack_control;
    logic       clear_status;
    logic       read_done;
    logic       transfer_done;
    logic [2:0] error_code;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  slave_address;
    logic        has_write;
    logic        has_read;
    logic [7:0]  write_count;
    logic [7:0]  read_count;
    logic [7:0]  data_byte;
    logic [15:0] error_flags;
  } entry_t;

endpackage

>>> hdl/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front: transaction classifier
// Matches status events against the known patterns, saturates byte counts
// and packs a queue entry for the back end.
// ----------------------------------------------------------------------------
module i2cms_front #(
  parameter int unsigned MAX_BYTES = 255
) (
  input  i2cms_pkg::in_item_t item,
  output i2cms_pkg::entry_t   entry
);
  import i2cms_pkg::*;

  localparam int unsigned CapInt = (MAX_BYTES > 255) ? 255 : MAX_BYTES;
  localparam logic [7:0] Cap = 8'(CapInt);

  always_comb begin
    entry               = '0;
    entry.slave_address = item.slave_address;
    entry.has_write     = item.has_write;
    entry.has_read      = item.has_read;
    entry.write_count   = (item.write_count > Cap) ? Cap : item.write_count;
    entry.read_count    = (item.read_count > Cap) ? Cap : item.read_count;
    entry.error_flags   = item.status_word[23:8];
    entry.data_byte     = item.write_byte;
    priority if (!item.kind) begin
      entry.op = OP_START;
    end else if (item.status_word == EV_START_SENT) begin
      entry.op = OP_START_SENT;
    end else if (item.status_word == EV_TX_ADDR_SENT ||
                 item.status_word == EV_TX_BYTE_DONE) begin
      entry.op = OP_TX_BYTE;
    end else if (item.status_word == EV_RX_ADDR_SENT) begin
      entry.op = OP_RX_ADDR;
    end else if (item.status_word == EV_RX_BYTE_READY) begin
      entry.op        = OP_RX_BYTE;
      entry.data_byte = item.read_byte;
    end else if ((item.status_word[15:0] & ERROR_FLAG_MASK) != '0) begin
      entry.op = OP_ERROR;
    end else begin
      entry.op = OP_OTHER;
    end
  end

endmodule

>>> hdl/i2cms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_queue: two-entry decoupling queue
// Holds classified transactions between the front and back ends.
// ----------------------------------------------------------------------------
module i2cms_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2cms_pkg::entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output i2cms_pkg::entry_t  head_entry
);
  import i2cms_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hdl/i2cms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_back: transfer sequencer
// Carries out queued transactions against the transfer state and
// registers one result per transaction.
// ----------------------------------------------------------------------------
module i2cms_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  i2cms_pkg::entry_t   head_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cms_pkg::out_item_t out_item
);
  import i2cms_pkg::*;

  logic [7:0]  bus_address_byte, bus_address_byte_next;
  logic [7:0]  writes_left, writes_left_next;
  logic [7:0]  reads_left, reads_left_next;
  logic [7:0]  position, position_next;
  logic        read_phase_wanted, read_phase_wanted_next;
  logic [15:0] error_bits, error_bits_next;
  out_item_t   result;

  function automatic logic [2:0] encode_error(input logic [15:0] bits);
    logic [2:0] code;
    code = ERR_NONE;
    if (bits != '0) begin
      code = ERR_UNLISTED;
      for (int i = 6; i >= 0; i--) begin
        if (bits[i]) begin
          code = 3'(i + 1);
        end
      end
    end
    return code;
  endfunction

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    bus_address_byte_next  = bus_address_byte;
    writes_left_next       = writes_left;
    reads_left_next        = reads_left;
    position_next          = position;
    read_phase_wanted_next = read_phase_wanted;
    error_bits_next        = error_bits;
    result                 = '0;
    unique case (head_entry.op)
      OP_START: begin
        if (head_entry.has_write) begin
          bus_address_byte_next = head_entry.slave_address & ~RW_BIT;
        end else if (head_entry.has_read) begin
          bus_address_byte_next = head_entry.slave_address | RW_BIT;
        end
        writes_left_next       = head_entry.write_count;
        reads_left_next        = head_entry.read_count;
        read_phase_wanted_next = head_entry.has_read;
        position_next          = '0;
        error_bits_next        = '0;
        result.ack_control     = ACK_ON;
        result.make_start      = 1'b1;
      end
      OP_START_SENT: begin
        result.send_address = 1'b1;
        result.out_byte     = bus_address_byte;
      end
      OP_TX_BYTE: begin
        if (writes_left != '0) begin
          result.send_data_byte = 1'b1;
          result.out_byte       = head_entry.data_byte;
          result.buffer_index   = position;
          position_next         = position + 8'd1;
          writes_left_next      = writes_left - 8'd1;
        end
        if (writes_left_next == '0) begin
          if (read_phase_wanted) begin
            bus_address_byte_next = bus_address_byte | RW_BIT;
            result.ack_control    = ACK_ON;
            result.make_start     = 1'b1;
            position_next         = '0;
          end else begin
            result.make_stop     = 1'b1;
            result.transfer_done = 1'b1;
          end
        end
      end
      OP_RX_ADDR: begin
        if (reads_left == 8'd1) begin
          result.ack_control = ACK_OFF;
        end
      end
      OP_RX_BYTE: begin
        if (reads_left != '0) begin
          result.store_read   = 1'b1;
          result.out_byte     = head_entry.data_byte;
          result.buffer_index = position;
          position_next       = position + 8'd1;
          reads_left_next     = reads_left - 8'd1;
        end
        if (reads_left_next == 8'd1) begin
          result.ack_control = ACK_OFF;
          result.make_stop   = 1'b1;
        end else if (reads_left_next == '0) begin
          result.make_stop     = 1'b1;
          result.read_done     = 1'b1;
          result.transfer_done = 1'b1;
        end
      end
      OP_ERROR: begin
        error_bits_next = head_entry.error_flags;
      end
      OP_OTHER: begin
        result.clear_status = 1'b1;
      end
      default: begin
        result.clear_status = 1'b1;
      end
    endcase
    result.error_code = encode_error(error_bits_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_address_byte  <= '0;
      writes_left       <= '0;
      reads_left        <= '0;
      position          <= '0;
      read_phase_wanted <= 1'b0;
      error_bits        <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (pop) begin
        bus_address_byte  <= bus_address_byte_next;
        writes_left       <= writes_left_next;
        reads_left        <= reads_left_next;
        position          <= position_next;
        read_phase_wanted <= read_phase_wanted_next;
        error_bits        <= error_bits_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= result;
    end
  end

  a_one_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.send_address && out_item.send_data_byte))
    else $error("address and data send in one result");

  a_start_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.make_start && out_item.make_stop))
    else $error("start and stop in one result");

  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.transfer_done) |-> out_item.make_stop)
    else $error("transfer done without stop");

  a_error_kept: assert property (@(posedge clk) disable iff (rst)
    (pop && head_entry.op != OP_START && head_entry.op != OP_ERROR)
      |=> $stable(error_bits))
    else $error("error bits changed by a non-error event");

endmodule

>>> hdl/i2c_master_event_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_event_sequencer_core: I2C master event sequencer
// A transaction is registered in the queue, then in the back end's output
// register. Throughput: one transaction per cycle while out_ready holds;
// the back end runs one per cycle; the two-entry queue absorbs output stalls.
// Reset: synchronous; clears the queue, output valid and all transfer state.
// ----------------------------------------------------------------------------
module i2c_master_event_sequencer_core #(
  parameter int unsigned MAX_BYTES = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cms_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cms_pkg::out_item_t  out_item
);
  import i2cms_pkg::*;

  entry_t front_entry;
  entry_t head_entry;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_head_valid;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  i2cms_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .item  (in_item),
    .entry (front_entry)
  );

  i2cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (head_entry)
  );

  i2cms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
